### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the frame allocator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed")
// When pre holds, post must hold in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed")
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop)
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif

`endif

### hw/rtl/bfa_pkg.sv
// Package: constants, codes and types of the bitmap frame allocator.
`timescale 1ns / 1ps

package bfa_pkg;

    localparam int MAX_FRAMES  = 65536;
    localparam int WORD_BITS   = 64;
    localparam int MAP_WORDS   = MAX_FRAMES / WORD_BITS;
    localparam int WORD_IDX_W  = $clog2(MAP_WORDS);
    localparam int BIT_IDX_W   = $clog2(WORD_BITS);
    localparam int FRAME_IDX_W = $clog2(MAX_FRAMES);
    localparam int CNT_W       = FRAME_IDX_W + 1;
    localparam int NWORDS_W    = WORD_IDX_W + 1;
    localparam int ADDR_W      = 48;
    localparam int FRAME_SHIFT = 12;
    localparam int DIFF_IDX_W  = ADDR_W - FRAME_SHIFT;
    localparam int MODE_W      = 2;
    localparam int IN_DATA_W   = 56;
    localparam int OUT_DATA_W  = 72;
    localparam int CFG_DATA_W  = 48;

    // Request codes
    localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_COUNT = 2'd2;

    // Register indexes
    localparam logic [0:0] REG_BASE_ADDRESS = 1'b0;
    localparam logic [0:0] REG_FRAME_COUNT  = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ALLOC_RD,
        ST_ALLOC_CHK,
        ST_ALLOC_BIT,
        ST_ALLOC_ADDR,
        ST_FREE_SUB,
        ST_FREE_CHK,
        ST_FREE_WR,
        ST_DONE
    } state_t;

endpackage

### hw/rtl/bitmap_frame_allocator.sv
// Top level: first-fit bitmap page-frame allocator with one 64-bit-word map memory.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// The allocator keeps one used bit per 4 KiB frame in a synchronous memory of
// 1024 words of 64 bits (registered read) and serves one request at a time. A
// count request, or an unused request code, goes straight to the result; a free
// runs subtract, range check, read and write back, and ends after the range
// check when the address falls outside the managed frames. An allocate reads and
// checks each map word it scans, then marks the free bit and forms the address;
// when it fails it ends after the scan. The scan starts at a hint, the lowest
// word that may still hold a free frame, so it usually reads a single word.
// The search for the free bit inside a word runs in two steps, byte then bit.
// After reset and after every write of frame_count, a clearing pass writes all
// 1024 map words, one per cycle, and no request is taken during the pass;
// configuration writes are still taken. A finished result sits in the output
// register, and the next request is taken while it waits there.
module bitmap_frame_allocator
    import bfa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Request stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // [1:0] mode, [49:2] frame_address
    // Result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [47:0] alloc_address, [48] success,
                                             // [65:49] free_count
    // Configuration write port
    input  logic                  cfg_we,
    input  logic [0:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Map memory
    logic [WORD_BITS-1:0]  mem [MAP_WORDS];
    logic                  mem_we;
    logic [WORD_IDX_W-1:0] mem_waddr;
    logic [WORD_BITS-1:0]  mem_wdata;
    logic                  mem_re;
    logic [WORD_IDX_W-1:0] mem_raddr;
    logic [WORD_BITS-1:0]  rdata_reg;

    // Control state
    state_t                state_reg, state_next;
    logic [ADDR_W-1:0]     base_reg, base_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [WORD_BITS-1:0]  tail_used_reg, tail_used_next;
    logic [CNT_W-1:0]      free_total_reg, free_total_next;
    logic [NWORDS_W-1:0]   hint_reg, hint_next;
    logic [NWORDS_W-1:0]   scan_w_reg, scan_w_next;
    logic [WORD_IDX_W-1:0] clr_idx_reg, clr_idx_next;
    logic                  out_valid_reg, out_valid_next;

    // Payload registers
    logic [ADDR_W-1:0]      addr_reg, addr_next;
    logic [DIFF_IDX_W-1:0]  diff_idx_reg, diff_idx_next;
    logic                   below_base_reg, below_base_next;
    logic [WORD_BITS-1:0]   word_reg, word_next;
    logic [2:0]             byte_idx_reg, byte_idx_next;
    logic [FRAME_IDX_W-1:0] frame_idx_reg, frame_idx_next;
    logic [ADDR_W-1:0]      res_addr_reg, res_addr_next;
    logic                   res_ok_reg, res_ok_next;
    logic [ADDR_W-1:0]      out_addr_reg, out_addr_next;
    logic                   out_ok_reg, out_ok_next;
    logic [CNT_W-1:0]       out_free_reg, out_free_next;

    // Derived values
    logic [NWORDS_W-1:0]  nwords;
    logic [WORD_BITS-1:0] masked_word;
    logic [7:0]           byte_has_free;
    logic [2:0]           first_byte;
    logic [7:0]           sel_byte;
    logic [2:0]           first_bit;
    logic [BIT_IDX_W-1:0] free_bit;
    logic [CNT_W-1:0]     cfg_count;
    logic [ADDR_W:0]      sub_full;
    logic [NWORDS_W-1:0]  free_word;

    // Words that hold at least one managed frame
    assign nwords = count_reg[CNT_W-1:BIT_IDX_W]
        + {{(NWORDS_W-1){1'b0}}, |count_reg[BIT_IDX_W-1:0]};

    // Frames at or above the count read as used in the last partial word
    assign masked_word = rdata_reg
        | ((scan_w_reg == count_reg[CNT_W-1:BIT_IDX_W]) ? tail_used_reg : '0);

    // First byte with a clear bit, then first clear bit in that byte
    always_comb
    begin
        first_byte = 3'd0;
        for (int k = 7; k >= 0; k--)
        begin
            byte_has_free[k] = ~&masked_word[k*8 +: 8];
            if (byte_has_free[k])
            begin
                first_byte = 3'(k);
            end
        end
    end

    assign sel_byte = word_reg[{byte_idx_reg, 3'b000} +: 8];

    always_comb
    begin
        first_bit = 3'd0;
        for (int k = 7; k >= 0; k--)
        begin
            if (!sel_byte[k])
            begin
                first_bit = 3'(k);
            end
        end
    end

    assign free_bit  = frame_idx_reg[BIT_IDX_W-1:0];
    assign free_word = {1'b0, frame_idx_reg[FRAME_IDX_W-1:BIT_IDX_W]};
    assign sub_full  = {1'b0, addr_reg} - {1'b0, base_reg};

    // Saturate the written frame count at the map capacity
    assign cfg_count = cfg_data[CNT_W-1] ? CNT_W'(MAX_FRAMES) : cfg_data[CNT_W-1:0];

    // Next state and datapath control
    always_comb
    begin
        state_next      = state_reg;
        base_next       = base_reg;
        count_next      = count_reg;
        tail_used_next  = tail_used_reg;
        free_total_next = free_total_reg;
        hint_next       = hint_reg;
        scan_w_next     = scan_w_reg;
        clr_idx_next    = clr_idx_reg;
        out_valid_next  = out_valid_reg;
        addr_next       = addr_reg;
        diff_idx_next   = diff_idx_reg;
        below_base_next = below_base_reg;
        word_next       = word_reg;
        byte_idx_next   = byte_idx_reg;
        frame_idx_next  = frame_idx_reg;
        res_addr_next   = res_addr_reg;
        res_ok_next     = res_ok_reg;
        out_addr_next   = out_addr_reg;
        out_ok_next     = out_ok_reg;
        out_free_next   = out_free_reg;
        mem_we          = 1'b0;
        mem_waddr       = scan_w_reg[WORD_IDX_W-1:0];
        mem_wdata       = word_reg;
        mem_re          = 1'b0;
        mem_raddr       = scan_w_reg[WORD_IDX_W-1:0];

        // Drop the output beat once it is taken
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                // Sweep the map; frame zero stays reserved
                mem_we       = 1'b1;
                mem_waddr    = clr_idx_reg;
                mem_wdata    = (clr_idx_reg == '0) ? WORD_BITS'(1) : '0;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == WORD_IDX_W'(MAP_WORDS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    addr_next     = s_tdata[MODE_W +: ADDR_W];
                    res_addr_next = '0;
                    res_ok_next   = 1'b0;
                    scan_w_next   = hint_reg;
                    case (s_tdata[MODE_W-1:0])
                        MODE_ALLOC: state_next = ST_ALLOC_RD;
                        MODE_FREE:  state_next = ST_FREE_SUB;
                        MODE_COUNT:
                        begin
                            res_ok_next = 1'b1;
                            state_next  = ST_DONE;
                        end
                        default:    state_next = ST_DONE;
                    endcase
                end
            end

            ST_ALLOC_RD:
            begin
                if (scan_w_reg >= nwords)
                begin
                    // Map full from the hint on: fail and remember it
                    hint_next  = nwords;
                    state_next = ST_DONE;
                end
                else
                begin
                    mem_re     = 1'b1;
                    state_next = ST_ALLOC_CHK;
                end
            end

            ST_ALLOC_CHK:
            begin
                if (&masked_word)
                begin
                    scan_w_next = scan_w_reg + 1'b1;
                    hint_next   = scan_w_reg + 1'b1;
                    state_next  = ST_ALLOC_RD;
                end
                else
                begin
                    word_next     = masked_word;
                    byte_idx_next = first_byte;
                    state_next    = ST_ALLOC_BIT;
                end
            end

            ST_ALLOC_BIT:
            begin
                frame_idx_next  = {scan_w_reg[WORD_IDX_W-1:0], byte_idx_reg, first_bit};
                mem_we          = 1'b1;
                mem_wdata       = word_reg | (WORD_BITS'(1) << {byte_idx_reg, first_bit});
                free_total_next = free_total_reg - 1'b1;
                hint_next       = scan_w_reg;
                state_next      = ST_ALLOC_ADDR;
            end

            ST_ALLOC_ADDR:
            begin
                res_addr_next = base_reg
                    + {{(ADDR_W-FRAME_IDX_W-FRAME_SHIFT){1'b0}}, frame_idx_reg,
                       {FRAME_SHIFT{1'b0}}};
                res_ok_next   = 1'b1;
                state_next    = ST_DONE;
            end

            ST_FREE_SUB:
            begin
                diff_idx_next   = sub_full[ADDR_W-1:FRAME_SHIFT];
                below_base_next = sub_full[ADDR_W];
                state_next      = ST_FREE_CHK;
            end

            ST_FREE_CHK:
            begin
                frame_idx_next = diff_idx_reg[FRAME_IDX_W-1:0];
                if (!below_base_reg
                    && (diff_idx_reg < {{(DIFF_IDX_W-CNT_W){1'b0}}, count_reg}))
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = diff_idx_reg[FRAME_IDX_W-1:BIT_IDX_W];
                    state_next = ST_FREE_WR;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end

            ST_FREE_WR:
            begin
                res_ok_next = 1'b1;
                if (rdata_reg[free_bit])
                begin
                    mem_we          = 1'b1;
                    mem_waddr       = frame_idx_reg[FRAME_IDX_W-1:BIT_IDX_W];
                    mem_wdata       = rdata_reg & ~(WORD_BITS'(1) << free_bit);
                    free_total_next = free_total_reg + 1'b1;
                    if (free_word < hint_reg)
                    begin
                        hint_next = free_word;
                    end
                end
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                // Hold the result until the output register is free
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_addr_next  = res_addr_reg;
                    out_ok_next    = res_ok_reg;
                    out_free_next  = free_total_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Configuration writes; a new frame count restarts the clearing pass
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BASE_ADDRESS:
                begin
                    base_next = cfg_data[ADDR_W-1:0];
                end
                REG_FRAME_COUNT:
                begin
                    count_next      = cfg_count;
                    tail_used_next  = (cfg_count[BIT_IDX_W-1:0] == '0) ? '0
                        : ~((WORD_BITS'(1) << cfg_count[BIT_IDX_W-1:0]) - WORD_BITS'(1));
                    free_total_next = (cfg_count == '0) ? '0 : cfg_count - 1'b1;
                    hint_next       = '0;
                    clr_idx_next    = '0;
                    state_next      = ST_CLEAR;
                end
                default:
                begin
                    base_next = base_reg;
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            base_reg       <= '0;
            count_reg      <= '0;
            tail_used_reg  <= '0;
            free_total_reg <= '0;
            hint_reg       <= '0;
            scan_w_reg     <= '0;
            clr_idx_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            base_reg       <= base_next;
            count_reg      <= count_next;
            tail_used_reg  <= tail_used_next;
            free_total_reg <= free_total_next;
            hint_reg       <= hint_next;
            scan_w_reg     <= scan_w_next;
            clr_idx_reg    <= clr_idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        addr_reg       <= addr_next;
        diff_idx_reg   <= diff_idx_next;
        below_base_reg <= below_base_next;
        word_reg       <= word_next;
        byte_idx_reg   <= byte_idx_next;
        frame_idx_reg  <= frame_idx_next;
        res_addr_reg   <= res_addr_next;
        res_ok_reg     <= res_ok_next;
        out_addr_reg   <= out_addr_next;
        out_ok_reg     <= out_ok_next;
        out_free_reg   <= out_free_next;
    end

    // Map memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W-ADDR_W-1-CNT_W){1'b0}}, out_free_reg, out_ok_reg,
                       out_addr_reg};

    `ASSERT_ALWAYS(a_free_within_count, clk, rst_n, free_total_reg <= count_reg);
    `ASSERT_ALWAYS(a_hint_in_range, clk, rst_n, hint_reg <= nwords);
    `ASSERT_ALWAYS(a_scan_in_range, clk, rst_n,
        (state_reg != ST_ALLOC_CHK) || (scan_w_reg < nwords));
    `ASSERT_NEXT(a_alloc_takes_one, clk, rst_n, (state_reg == ST_ALLOC_BIT) && !cfg_we,
        free_total_reg == $past(free_total_reg) - 1'b1);
    `ASSERT_NEXT(a_count_write_clears, clk, rst_n,
        cfg_we && (cfg_index == REG_FRAME_COUNT),
        (state_reg == ST_CLEAR) && (clr_idx_reg == '0) && !s_tready);

endmodule

### tb/bitmap_frame_allocator_tb.sv
// Testbench for the first-fit bitmap frame allocator: directed and random requests, self-checking.
`timescale 1ns / 1ps

module bitmap_frame_allocator_tb;
    import bfa_pkg::*;

    // The package has no name for request code 3; the block must ignore it
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    localparam logic [ADDR_W-1:0] PAGE_BYTES = ADDR_W'(1) << FRAME_SHIFT;
    // Longest receiver hold-off used to back the block up
    localparam int HOLD_LEN = 200;
    // Worst quiet stretch: clearing pass + full-map scan + hold-off;
    // take it several times over
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int ITEMS_PER_PHASE = 130;
    localparam int RANDOM_PHASES = 7;

    // One result beat, laid out as in m_tdata from bit 0 up
    typedef struct packed {
        logic [CNT_W-1:0]  free_count;
        logic              success;
        logic [ADDR_W-1:0] alloc_address;
    } grant_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;    // [1:0] mode, [49:2] frame_address
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;    // [47:0] alloc_address, [48] success, [65:49] free_count
    logic                  cfg_we;
    logic [0:0]            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Shadow of the allocator: occupancy map, registers and free counter
    logic [WORD_BITS-1:0] frame_map [MAP_WORDS];
    logic [ADDR_W-1:0]    base_reg;
    logic [CNT_W-1:0]     frame_total;
    logic [CNT_W-1:0]     free_frames;
    int unsigned          top_used;

    grant_t pending_grants [$];

    // Stimulus controls shared with the receiver process
    bit          idle_on;
    bit          hold_req;
    int unsigned hold_left;
    int unsigned stall_left;
    int unsigned quiet_cycles;

    int unsigned n_requests;
    int unsigned n_results;
    int unsigned n_granted;
    int unsigned n_refused;
    int unsigned n_freed;
    int unsigned n_free_ignored;
    int unsigned n_cfg_writes;
    int unsigned n_errors;
    int unsigned n_reports;

    bitmap_frame_allocator DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Apply one request to the shadow map and return the beat the block must produce.
    // Allocation is first fit over whole words: skip a word with no clear bit, then
    // take its lowest clear bit below the frame count.
    function automatic grant_t serve_request(logic [MODE_W-1:0] mode, logic [ADDR_W-1:0] addr);
        grant_t            g;
        logic [ADDR_W-1:0] frame_off;
        int unsigned       idx;
        bit                found;
        g = '0;
        found = 1'b0;
        case (mode)
            MODE_ALLOC:
            begin
                for (int w = 0; w < MAP_WORDS && w * WORD_BITS < frame_total && !found; w++)
                begin
                    if (frame_map[w] != '1)
                    begin
                        for (int b = 0; b < WORD_BITS && !found; b++)
                        begin
                            idx = w * WORD_BITS + b;
                            if (idx < frame_total && !frame_map[w][b])
                            begin
                                found = 1'b1;
                                frame_map[w][b] = 1'b1;
                                free_frames = free_frames - 1'b1;
                                // Address wraps modulo 2^48
                                g.alloc_address = base_reg + (ADDR_W'(idx) << FRAME_SHIFT);
                                g.success = 1'b1;
                                if (idx > top_used)
                                    top_used = idx;
                            end
                        end
                    end
                end
                if (found)
                    n_granted++;
                else
                    n_refused++;
            end
            MODE_FREE:
            begin
                // Ignore addresses below the base or past the last managed frame
                if (addr >= base_reg)
                begin
                    frame_off = (addr - base_reg) >> FRAME_SHIFT;
                    if (frame_off < ADDR_W'(frame_total))
                    begin
                        idx = frame_off[31:0];
                        // Freeing a frame that is already free leaves the count alone
                        if (frame_map[idx / WORD_BITS][idx % WORD_BITS])
                        begin
                            frame_map[idx / WORD_BITS][idx % WORD_BITS] = 1'b0;
                            free_frames = free_frames + 1'b1;
                        end
                        g.success = 1'b1;
                    end
                end
                if (g.success)
                    n_freed++;
                else
                    n_free_ignored++;
            end
            MODE_COUNT:
                g.success = 1'b1;
            default:
                g.success = 1'b0;
        endcase
        g.free_count = free_frames;
        return g;
    endfunction

    // Write one register and mirror it. A frame_count write clears the map, reserves
    // frame zero and saturates at the map capacity.
    task automatic write_reg(logic [0:0] index, logic [CFG_DATA_W-1:0] data);
        logic [CNT_W-1:0] cnt;
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        n_cfg_writes++;
        if (index == REG_BASE_ADDRESS)
            base_reg = data[ADDR_W-1:0];
        else
        begin
            cnt = data[CNT_W-1:0];
            if (cnt > MAX_FRAMES)
                cnt = CNT_W'(MAX_FRAMES);
            frame_total = cnt;
            foreach (frame_map[w])
                frame_map[w] = '0;
            top_used = 0;
            free_frames = '0;
            if (cnt != 0)
            begin
                frame_map[0][0] = 1'b1;
                free_frames = cnt - 1'b1;
            end
        end
    endtask

    // Offer one request beat and hold it until taken. An optional gap precedes it.
    // tready is sampled at the falling edge, so the beat is known to move at the
    // next rising edge without racing the block's own updates.
    task automatic send_req(logic [MODE_W-1:0] mode, logic [ADDR_W-1:0] addr);
        bit rdy;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_DATA_W - ADDR_W - MODE_W){1'b0}}, addr, mode};
        do
        begin
            @(negedge clk);
            rdy = s_tready;
            @(posedge clk);
        end
        while (!rdy);
        pending_grants.push_back(serve_request(mode, addr));
        n_requests++;
    endtask

    // Drop valid and wait until every predicted result has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_grants.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [ADDR_W-1:0] pick_base();
        int unsigned sel;
        sel = $urandom_range(0, 3);
        if (sel < 2)
            return ADDR_W'({$urandom, $urandom}) & ~(PAGE_BYTES - 1'b1);
        else if (sel == 2)
            return '1 - ADDR_W'($urandom_range(0, 1 << 22));    // near the top: grants wrap
        else
            return ADDR_W'({$urandom, $urandom});
    endfunction

    // Random request mix: allocs and frees dominate; frees mostly hit frames the map
    // has handed out, the rest land past the count, below the base or anywhere
    task automatic send_random_req();
        int unsigned       pick;
        int unsigned       sel;
        int unsigned       idx;
        logic [MODE_W-1:0] mode;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] offs;
        pick = $urandom_range(0, 99);
        addr = ADDR_W'({$urandom, $urandom});
        offs = ADDR_W'($urandom_range(0, (1 << FRAME_SHIFT) - 1));
        if (pick < 45)
            mode = MODE_ALLOC;
        else if (pick < 80)
        begin
            mode = MODE_FREE;
            sel = $urandom_range(0, 9);
            if (sel < 7)
            begin
                idx = $urandom_range(0, top_used);
                addr = base_reg + (ADDR_W'(idx) << FRAME_SHIFT) + offs;
            end
            else if (sel == 7)
            begin
                idx = frame_total + $urandom_range(0, 3);
                addr = base_reg + (ADDR_W'(idx) << FRAME_SHIFT) + offs;
            end
            else if (sel == 8)
                addr = base_reg - ADDR_W'($urandom_range(1, 1 << 20));
        end
        else if (pick < 93)
            mode = MODE_COUNT;
        else
            mode = MODE_UNUSED;
        send_req(mode, addr);
    endtask

    // Right after reset no frame is managed: allocs fail and frees are ignored
    task automatic test_zero_frames();
        send_req(MODE_ALLOC, '0);
        send_req(MODE_FREE, '0);
        send_req(MODE_COUNT, '0);
        send_req(MODE_UNUSED, '1);
        drain();
    endtask

    // Four frames: fill the map, run it full, then walk each free corner case
    task automatic test_small_map();
        logic [ADDR_W-1:0] base;
        base = 48'h0000_1234_5000;
        write_reg(REG_BASE_ADDRESS, CFG_DATA_W'(base));
        write_reg(REG_FRAME_COUNT, CFG_DATA_W'(4));
        repeat (3) send_req(MODE_ALLOC, '0);
        send_req(MODE_ALLOC, '1);                                   // map full
        send_req(MODE_FREE, base + 2 * PAGE_BYTES + PAGE_BYTES - 1);
        send_req(MODE_FREE, base + 2 * PAGE_BYTES);                 // already free
        send_req(MODE_FREE, base - 1'b1);                           // below base
        send_req(MODE_FREE, base + 4 * PAGE_BYTES);                 // past the count
        send_req(MODE_ALLOC, '0);
        send_req(MODE_FREE, base);                                  // release frame zero
        send_req(MODE_ALLOC, '0);
        send_req(MODE_COUNT, '0);
        drain();
    endtask

    // Top base (grants wrap past 2^48), count above capacity, then a single frame
    task automatic test_extremes();
        write_reg(REG_BASE_ADDRESS, CFG_DATA_W'({ADDR_W{1'b1}}));
        write_reg(REG_FRAME_COUNT, {{(CFG_DATA_W - CNT_W){1'b1}}, {CNT_W{1'b1}}});
        send_req(MODE_ALLOC, '0);
        send_req(MODE_ALLOC, '0);
        send_req(MODE_FREE, '1);
        send_req(MODE_FREE, '0);
        send_req(MODE_COUNT, '1);
        drain();
        write_reg(REG_FRAME_COUNT, CFG_DATA_W'(1));
        send_req(MODE_ALLOC, '0);
        send_req(MODE_COUNT, '0);
        drain();
    endtask

    // Several map sizes, small ones most often so the map runs full; odd phases
    // move the base halfway through while keeping the map
    task automatic test_random_traffic();
        logic [CNT_W-1:0] cnt;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0: cnt = CNT_W'(5);
                1: cnt = CNT_W'($urandom_range(2, 64));
                2: cnt = CNT_W'(MAX_FRAMES);
                3: cnt = CNT_W'($urandom_range(MAX_FRAMES + 1, (1 << CNT_W) - 1));
                4: cnt = CNT_W'($urandom_range(100, 700));
                5: cnt = CNT_W'($urandom_range(1, 40));
                default: cnt = CNT_W'($urandom_range(2, 300));
            endcase
            write_reg(REG_BASE_ADDRESS, CFG_DATA_W'(pick_base()));
            write_reg(REG_FRAME_COUNT, {(CFG_DATA_W - CNT_W)'($urandom), cnt});
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                if (p % 2 == 1 && i == ITEMS_PER_PHASE / 2)
                begin
                    drain();
                    write_reg(REG_BASE_ADDRESS, CFG_DATA_W'(pick_base()));
                end
                send_random_req();
            end
            drain();
        end
    endtask

    // Hold the result side off for a long stretch while requests keep coming,
    // so the block backs up and drops tready. The hold starts once the first
    // request is in, after the clearing pass.
    task automatic test_backpressure();
        idle_on = 1'b0;
        write_reg(REG_FRAME_COUNT, CFG_DATA_W'(40));
        send_random_req();
        hold_req = 1'b1;
        repeat (15) send_random_req();
        drain();
        idle_on = 1'b1;
    endtask

    // Closing stretch at full rate on both sides
    task automatic test_full_rate();
        idle_on = 1'b0;
        write_reg(REG_BASE_ADDRESS, CFG_DATA_W'(pick_base()));
        write_reg(REG_FRAME_COUNT, CFG_DATA_W'(24));
        repeat (100) send_random_req();
        drain();
    endtask

    // Result side: random stall bursts, or one long hold-off when asked
    always @(posedge clk)
    begin
        logic ready_nxt;
        ready_nxt = 1'b1;
        if (hold_left != 0)
        begin
            hold_left--;
            ready_nxt = 1'b0;
        end
        else if (hold_req)
        begin
            hold_req = 1'b0;
            hold_left = HOLD_LEN - 1;
            ready_nxt = 1'b0;
        end
        else if (stall_left != 0)
        begin
            stall_left--;
            ready_nxt = 1'b0;
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(0, 14);
            ready_nxt = 1'b0;
        end
        m_tready <= ready_nxt;
    end

    // Check each result beat against the oldest prediction. Sample at the falling
    // edge: the beat moves at the next rising edge.
    always @(negedge clk)
    begin
        grant_t got;
        grant_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[$bits(grant_t)-1:0];
            if (pending_grants.size() == 0)
            begin
                n_errors++;
                if (n_reports < 10)
                begin
                    n_reports++;
                    $display("%0t: unexpected result beat addr=%h ok=%b free=%0d",
                             $realtime, got.alloc_address, got.success, got.free_count);
                end
            end
            else
            begin
                want = pending_grants.pop_front();
                n_results++;
                if (got.alloc_address !== want.alloc_address || got.success !== want.success
                    || got.free_count !== want.free_count)
                begin
                    n_errors++;
                    if (n_reports < 10)
                    begin
                        n_reports++;
                        $display("%0t: result %0d mismatch: expected addr=%h ok=%b free=%0d,",
                                 $realtime, n_results, want.alloc_address, want.success,
                                 want.free_count);
                        $display("    got addr=%h ok=%b free=%0d",
                                 got.alloc_address, got.success, got.free_count);
                    end
                end
            end
        end
    end

    // Watchdog: give up after too long with no beat on any port
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Watchdog: no beat for %0d cycles, %0d results outstanding",
                         quiet_cycles, pending_grants.size());
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        m_tready  <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;

        // Shadow state after reset: nothing managed, frame zero marked used
        foreach (frame_map[w])
            frame_map[w] = '0;
        frame_map[0][0] = 1'b1;
        base_reg    = '0;
        frame_total = '0;
        free_frames = '0;
        top_used    = 0;
        idle_on     = 1'b1;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_zero_frames();
        test_small_map();
        test_extremes();
        test_random_traffic();
        test_backpressure();
        test_full_rate();

        // Let any stray beat show up before closing
        repeat (20) @(posedge clk);
        n_errors += pending_grants.size();

        $display("Ran %0d requests across %0d register writes: %0d frames granted,",
                 n_requests, n_cfg_writes, n_granted);
        $display("%0d allocs refused, %0d frees taken, %0d frees ignored,",
                 n_refused, n_freed, n_free_ignored);
        $display("%0d results checked, %0d errors.", n_results, n_errors);
        if (n_errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
